>>> hw/rtl/world_point_to_screen_projection_assert.svh
// Assertion macros shared by the projection RTL; empty under synthesis.
`ifndef WORLD_POINT_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_POINT_TO_SCREEN_PROJECTION_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define WPSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define WPSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPSP_ASSERT(label, prop, msg)
`define WPSP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> hw/rtl/wpsp_pkg.sv
// Shared widths, codes and types of the world-point-to-screen projection.
package wpsp_pkg;

  // Fixed field and register widths
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int SCREEN_W  = 32;
  localparam int PIX_W     = 16;
  localparam int EPS_W     = 16;
  localparam int FRAC_W    = 16;

  // Internal arithmetic widths, sized to the value ranges
  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CLIP_W = 49;
  localparam int NUM_W  = CLIP_W + 1;
  localparam int MAG_W  = CLIP_W;
  localparam int MW_W   = MAG_W + PIX_W;
  localparam int DEN_W  = CLIP_W - 1;
  localparam int QBITS  = COORD_W - 1;
  localparam int PAD_W  = QBITS - FRAC_W;

  // Matrix rows, columns and screen lanes
  localparam int NROWS  = 3;
  localparam int NCOLS  = 3;
  localparam int NLANES = 2;
  localparam int ROW_X  = 0;
  localparam int ROW_Y  = 1;
  localparam int ROW_W  = 2;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {QBITS{1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {QBITS{1'b0}}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_RES = 2'd1,
    ST_W_SMALL  = 2'd2,
    ST_BEHIND   = 2'd3
  } wpsp_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X_01    = 3'd0,
    REG_ROW_X_23    = 3'd1,
    REG_ROW_Y_01    = 3'd2,
    REG_ROW_Y_23    = 3'd3,
    REG_ROW_W_01    = 3'd4,
    REG_ROW_W_23    = 3'd5,
    REG_SCREEN_SIZE = 3'd6,
    REG_W_EPSILON   = 3'd7
  } wpsp_reg_t;

  // Control carried beside each word through the pipeline
  typedef struct packed {
    logic         valid;
    wpsp_status_t status;
  } wpsp_tag_t;

  // One finished result word
  typedef struct packed {
    wpsp_status_t       status;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } wpsp_res_t;

endpackage

>>> hw/rtl/wpsp_clip.sv
// Three-stage clip-space transform: products, row sums, floor and offset.
module wpsp_clip
  import wpsp_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [COORD_W-1:0]       pt_x,
  input  logic signed [COORD_W-1:0]       pt_y,
  input  logic signed [COORD_W-1:0]       pt_z,
  input  logic [NROWS-1:0][CFG_W-1:0]     rows01,
  input  logic [NROWS-1:0][CFG_W-1:0]     rows23,
  output logic                            out_valid,
  output logic [NROWS-1:0][CLIP_W-1:0]    clip
);

  localparam int STAGES = 3;

  logic signed [COORD_W-1:0] pt   [NCOLS];
  logic signed [COORD_W-1:0] coef [NROWS][NCOLS];
  logic signed [COORD_W-1:0] offs [NROWS];

  logic signed [PROD_W-1:0] prod_nxt [NROWS][NCOLS];
  logic signed [PROD_W-1:0] prod_r   [NROWS][NCOLS];
  logic signed [SUM_W-1:0]  sum_nxt  [NROWS];
  logic signed [SUM_W-1:0]  sum_r    [NROWS];
  logic signed [CLIP_W-1:0] clip_nxt [NROWS];
  logic signed [CLIP_W-1:0] clip_r   [NROWS];
  logic [STAGES-1:0]        val_r;

  // Unpack matrix entries and the point
  always_comb begin
    pt[0] = pt_x;
    pt[1] = pt_y;
    pt[2] = pt_z;
    for (int r = 0; r < NROWS; r++) begin
      coef[r][0] = $signed(rows01[r][COORD_W-1:0]);
      coef[r][1] = $signed(rows01[r][CFG_W-1:COORD_W]);
      coef[r][2] = $signed(rows23[r][COORD_W-1:0]);
      offs[r]    = $signed(rows23[r][CFG_W-1:COORD_W]);
    end
  end

  // Form exact products, then exact row sums, then floor to Q16.16 plus offset
  always_comb begin
    for (int r = 0; r < NROWS; r++) begin
      for (int c = 0; c < NCOLS; c++) begin
        prod_nxt[r][c] = PROD_W'(coef[r][c]) * PROD_W'(pt[c]);
      end
      sum_nxt[r]  = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2]);
      clip_nxt[r] = CLIP_W'(sum_r[r] >>> FRAC_W) + CLIP_W'(offs[r]);
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      clip_r <= clip_nxt;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= {val_r[STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    for (int r = 0; r < NROWS; r++) begin
      clip[r] = clip_r[r];
    end
  end

  assign out_valid = val_r[STAGES-1];

endmodule

>>> hw/rtl/wpsp_div.sv
// Pipelined restoring divider, two lanes, one quotient bit per stage.
module wpsp_div
  import wpsp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  wpsp_tag_t                     in_tag,
  input  logic [DEN_W-1:0]              in_den,
  input  logic [NLANES-1:0][MW_W-1:0]   in_mw,
  input  logic [NLANES-1:0]             in_neg,
  output wpsp_tag_t                     out_tag,
  output logic [NLANES-1:0]             out_neg,
  output logic [NLANES-1:0]             out_ovf,
  output logic [NLANES-1:0][QBITS-1:0]  out_quo
);

  logic              val_r  [QBITS+1];
  wpsp_status_t      stat_r [QBITS+1];
  logic [DEN_W-1:0]  den_r  [QBITS+1];
  logic [NLANES-1:0] neg_r  [QBITS+1];
  logic [NLANES-1:0] ovf_r  [QBITS+1];
  logic [DEN_W-1:0]  rem_r  [QBITS+1][NLANES];
  logic [QBITS-1:0]  quo_r  [QBITS+1][NLANES];
  logic [QBITS-1:0]  low_r  [QBITS+1][NLANES];

  logic [NLANES-1:0] ovf0_nxt;

  // Flag quotients of 2^31 or more; the rest of the numerator feeds the steps
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      ovf0_nxt[l] = in_mw[l][MW_W-1:FRAC_W] >= (DEN_W+1)'(in_den);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stat_r[0] <= in_tag.status;
      den_r[0]  <= in_den;
      neg_r[0]  <= in_neg;
      ovf_r[0]  <= ovf0_nxt;
      for (int l = 0; l < NLANES; l++) begin
        rem_r[0][l] <= in_mw[l][DEN_W+FRAC_W-1:FRAC_W];
        quo_r[0][l] <= '0;
        low_r[0][l] <= {in_mw[l][FRAC_W-1:0], PAD_W'(0)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r[0] <= 1'b0;
    end else if (en) begin
      val_r[0] <= in_tag.valid;
    end
  end

  // One trial subtract per stage
  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [DEN_W:0]    trial [NLANES];
    logic [DEN_W:0]    diff  [NLANES];
    logic [NLANES-1:0] ge;

    always_comb begin
      for (int l = 0; l < NLANES; l++) begin
        trial[l] = {rem_r[k][l], low_r[k][l][QBITS-1]};
        diff[l]  = trial[l] - (DEN_W+1)'(den_r[k]);
        ge[l]    = trial[l] >= (DEN_W+1)'(den_r[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stat_r[k+1] <= stat_r[k];
        den_r[k+1]  <= den_r[k];
        neg_r[k+1]  <= neg_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        for (int l = 0; l < NLANES; l++) begin
          rem_r[k+1][l] <= ge[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
          quo_r[k+1][l] <= {quo_r[k][l][QBITS-2:0], ge[l]};
          low_r[k+1][l] <= low_r[k][l] << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k+1] <= 1'b0;
      end else if (en) begin
        val_r[k+1] <= val_r[k];
      end
    end
  end

  always_comb begin
    out_tag.valid  = val_r[QBITS];
    out_tag.status = stat_r[QBITS];
    out_neg        = neg_r[QBITS];
    out_ovf        = ovf_r[QBITS];
    for (int l = 0; l < NLANES; l++) begin
      out_quo[l] = quo_r[QBITS][l];
    end
  end

endmodule

>>> hw/rtl/world_point_to_screen_projection.sv
// Top level of the world-point-to-screen projection. One point enters per
// clock and one result word leaves per clock, sustained while out_ready is
// high; the whole pipeline stalls while the skid stage holds a word. A point
// passes three clip stages (multiply, row sum, floor and offset), three
// preparation stages (numerator and status, magnitude, pixel scaling), one
// overflow stage, a restoring divide of 31 stages (one quotient bit per
// stage) and the output register, which a one-word skid stage backs to
// decouple the channels: in_ready depends only on the skid stage being
// empty. The user must write the matrix, screen size and epsilon registers
// through the cfg port only while no point is in flight; the block does not enforce it.
`include "world_point_to_screen_projection_assert.svh"

module world_point_to_screen_projection
  import wpsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [COORD_W-1:0] out_screen_x,
  output logic signed [COORD_W-1:0] out_screen_y
);

  // Configuration registers
  logic [NROWS-1:0][CFG_W-1:0] rows01_r;
  logic [NROWS-1:0][CFG_W-1:0] rows23_r;
  logic [SCREEN_W-1:0]         screen_r;
  logic [EPS_W-1:0]            eps_r;
  logic [PIX_W-1:0]            pix [NLANES];

  logic en;

  // Clip stage outputs
  logic                         clip_valid;
  logic [NROWS-1:0][CLIP_W-1:0] clip;
  logic signed [CLIP_W-1:0]     cx, cy, cw;
  logic signed [CLIP_W-1:0]     eps_s, eps_neg;
  logic                         w_small;

  // Numerator and status stage
  wpsp_status_t             stat_nxt;
  logic signed [NUM_W-1:0]  num_nxt  [NLANES];
  logic signed [NUM_W-1:0]  num_r    [NLANES];
  logic                     n_val_r;
  wpsp_status_t             n_stat_r;
  logic [DEN_W-1:0]         n_den_r;

  // Magnitude stage
  logic [MAG_W-1:0]         mag_nxt  [NLANES];
  logic [MAG_W-1:0]         mag_r    [NLANES];
  logic [NLANES-1:0]        a_neg_r;
  logic                     a_val_r;
  wpsp_status_t             a_stat_r;
  logic [DEN_W-1:0]         a_den_r;

  // Pixel scaling stage
  logic [NLANES-1:0][MW_W-1:0] mw_nxt;
  logic [NLANES-1:0][MW_W-1:0] mw_r;
  logic [NLANES-1:0]           m_neg_r;
  logic                        m_val_r;
  wpsp_status_t                m_stat_r;
  logic [DEN_W-1:0]            m_den_r;
  wpsp_tag_t                   m_tag;

  // Divider outputs
  wpsp_tag_t                  d_tag;
  logic [NLANES-1:0]          d_neg;
  logic [NLANES-1:0]          d_ovf;
  logic [NLANES-1:0][QBITS-1:0] d_quo;

  // Output register and skid stage
  wpsp_res_t res_word;
  wpsp_res_t out_word_nxt;
  wpsp_res_t out_word_r;
  wpsp_res_t skid_word_r;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  logic      out_load, skid_load;

  // Saturate a quotient to a signed Q16.16 coordinate
  function automatic logic signed [COORD_W-1:0] fmt_coord(
    input logic             neg,
    input logic             ovf,
    input logic [QBITS-1:0] quo
  );
    logic signed [COORD_W-1:0] mag;
    logic signed [COORD_W-1:0] val;
    mag = $signed({1'b0, quo});
    if (neg) begin
      val = ovf ? COORD_MIN : -mag;
    end else begin
      val = ovf ? COORD_MAX : mag;
    end
    return val;
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows01_r <= '0;
      rows23_r <= '0;
      screen_r <= '0;
      eps_r    <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X_01:    rows01_r[ROW_X] <= cfg_wdata;
        REG_ROW_X_23:    rows23_r[ROW_X] <= cfg_wdata;
        REG_ROW_Y_01:    rows01_r[ROW_Y] <= cfg_wdata;
        REG_ROW_Y_23:    rows23_r[ROW_Y] <= cfg_wdata;
        REG_ROW_W_01:    rows01_r[ROW_W] <= cfg_wdata;
        REG_ROW_W_23:    rows23_r[ROW_W] <= cfg_wdata;
        REG_SCREEN_SIZE: screen_r        <= cfg_wdata[SCREEN_W-1:0];
        REG_W_EPSILON:   eps_r           <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix[LANE_X] = screen_r[PIX_W-1:0];
  assign pix[LANE_Y] = screen_r[SCREEN_W-1:PIX_W];

  // Advance the whole pipeline whenever the skid stage is empty
  assign en       = !skid_valid_r;
  assign in_ready = en;

  wpsp_clip u_clip (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .pt_x      (in_point_x),
    .pt_y      (in_point_y),
    .pt_z      (in_point_z),
    .rows01    (rows01_r),
    .rows23    (rows23_r),
    .out_valid (clip_valid),
    .clip      (clip)
  );

  // Form numerators and classify the point
  always_comb begin
    cx      = $signed(clip[ROW_X]);
    cy      = $signed(clip[ROW_Y]);
    cw      = $signed(clip[ROW_W]);
    eps_s   = $signed(CLIP_W'(eps_r));
    eps_neg = -eps_s;
    w_small = (cw == '0) || (cw[CLIP_W-1] ? (cw > eps_neg) : (cw < eps_s));
    num_nxt[LANE_X] = NUM_W'(cw) + NUM_W'(cx);
    num_nxt[LANE_Y] = NUM_W'(cw) - NUM_W'(cy);
    priority if (pix[LANE_X] == '0 || pix[LANE_Y] == '0) begin
      stat_nxt = ST_ZERO_RES;
    end else if (w_small) begin
      stat_nxt = ST_W_SMALL;
    end else if (cw[CLIP_W-1]) begin
      stat_nxt = ST_BEHIND;
    end else begin
      stat_nxt = ST_OK;
    end
  end

  // Take magnitudes and scale by the screen size
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      mag_nxt[l] = num_r[l][NUM_W-1] ? MAG_W'(-num_r[l]) : MAG_W'(num_r[l]);
      mw_nxt[l]  = MW_W'(mag_r[l]) * MW_W'(pix[l]);
    end
  end

  // Advance preparation data
  always_ff @(posedge clk) begin
    if (en) begin
      num_r    <= num_nxt;
      n_stat_r <= stat_nxt;
      n_den_r  <= cw[DEN_W-1:0];
      mag_r    <= mag_nxt;
      for (int l = 0; l < NLANES; l++) begin
        a_neg_r[l] <= num_r[l][NUM_W-1];
      end
      a_stat_r <= n_stat_r;
      a_den_r  <= n_den_r;
      mw_r     <= mw_nxt;
      m_neg_r  <= a_neg_r;
      m_stat_r <= a_stat_r;
      m_den_r  <= a_den_r;
    end
  end

  // Advance preparation valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_val_r <= 1'b0;
      a_val_r <= 1'b0;
      m_val_r <= 1'b0;
    end else if (en) begin
      n_val_r <= clip_valid;
      a_val_r <= n_val_r;
      m_val_r <= a_val_r;
    end
  end

  assign m_tag.valid  = m_val_r;
  assign m_tag.status = m_stat_r;

  wpsp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_tag  (m_tag),
    .in_den  (m_den_r),
    .in_mw   (mw_r),
    .in_neg  (m_neg_r),
    .out_tag (d_tag),
    .out_neg (d_neg),
    .out_ovf (d_ovf),
    .out_quo (d_quo)
  );

  // Assemble the result word; rejected points carry zero coordinates
  always_comb begin
    res_word.status = d_tag.status;
    if (d_tag.status == ST_OK) begin
      res_word.x = fmt_coord(d_neg[LANE_X], d_ovf[LANE_X], d_quo[LANE_X]);
      res_word.y = fmt_coord(d_neg[LANE_Y], d_ovf[LANE_Y], d_quo[LANE_Y]);
    end else begin
      res_word.x = '0;
      res_word.y = '0;
    end
  end

  // Steer words into the output register or the skid stage
  always_comb begin
    out_load       = 1'b0;
    skid_load      = 1'b0;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = skid_valid_r ? skid_word_r : res_word;
    priority if (skid_valid_r) begin
      if (out_ready) begin
        out_load       = 1'b1;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_valid_r && !out_ready) begin
      if (d_tag.valid) begin
        skid_load      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else begin
      out_load      = 1'b1;
      out_valid_nxt = d_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
    if (skid_load) begin
      skid_word_r <= res_word;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_word_r.status;
  assign out_screen_x = out_word_r.x;
  assign out_screen_y = out_word_r.y;

  // Checks
  `WPSP_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid word held without an output word")
  `WPSP_ASSERT(a_reject_zero, (out_valid_r && out_word_r.status != ST_OK) |-> (out_word_r.x == '0 && out_word_r.y == '0), "rejected word carries coordinates")
  `WPSP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_r && !skid_valid_r), "output not empty after reset")

endmodule
